// ----- rtl/char_stream_tokenizer_assert.svh -----
// assertion macros shared by the tokenizer modules
// every check is sampled on clock and is off while reset is high
`ifndef CHAR_STREAM_TOKENIZER_ASSERT_SVH
`define CHAR_STREAM_TOKENIZER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CST_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// consequent must hold in the cycle after the antecedent
`define CST_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

// ----- rtl/cst_pkg.sv -----
package cst_pkg;

   // token kind codes on the result channel
   typedef enum logic [4:0] {
      TK_INT    = 5'd0,
      TK_FLOAT  = 5'd1,
      TK_COUT   = 5'd2,
      TK_LSHIFT = 5'd3,
      TK_LPAREN = 5'd4,
      TK_RPAREN = 5'd5,
      TK_ADD    = 5'd6,
      TK_MUL    = 5'd7,
      TK_IDENT  = 5'd8,
      TK_NUM    = 5'd9,
      TK_ERROR  = 5'd10,
      TK_END    = 5'd11,
      TK_EQUAL  = 5'd12,
      TK_SEMI   = 5'd13,
      TK_VOID   = 5'd14,
      TK_LCURLY = 5'd15,
      TK_RCURLY = 5'd16
   } tok_type;

   // input word kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOI  = 1'b1;

   // keyword tables: int, float, cout, void
   localparam int NUM_KW = 4;
   localparam int LEN_W  = 3;
   localparam logic [7:0] KW_CHAR [NUM_KW][2**LEN_W] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "l", "o", "a",   "t",   8'h00, 8'h00, 8'h00},
      '{"c", "o", "u", "t",   8'h00, 8'h00, 8'h00, 8'h00},
      '{"v", "o", "i", "d",   8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{3'd3, 3'd5, 3'd4, 3'd4};
   localparam tok_type KW_TOK [NUM_KW] = '{TK_INT, TK_FLOAT, TK_COUT, TK_VOID};

   // token queue between scanner and output side (depth a power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one queue word: one or two tokens caused by one input word
   typedef struct packed {
      logic    two;
      tok_type tok_a;
      tok_type tok_b;
   } tok_entry_type;

   // queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ----- rtl/cst_front.sv -----
module cst_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   input  logic [7:0]            req_ch,
   output logic                  req_stall,
   input  cst_pkg::q_status_type q_status,
   output logic                  push,
   output cst_pkg::tok_entry_type push_entry
);

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_INT     = 3'd1,
      MODE_LEADDOT = 3'd2,
      MODE_FRAC    = 3'd3,
      MODE_IDENT   = 3'd4,
      MODE_LESS    = 3'd5
   } mode_type;

   mode_type                        mode_ff, mode_in;
   logic [cst_pkg::NUM_KW-1:0]      flags_ff, flags_in;
   logic [cst_pkg::LEN_W-1:0]       len_ff, len_in;

   logic                            accept;
   logic                            is_digit, is_alpha, is_space;
   logic [cst_pkg::NUM_KW-1:0]      start_flags, cont_flags;
   logic [cst_pkg::LEN_W-1:0]       len_sat;
   cst_pkg::tok_type                ident_tok;
   mode_type                        idle_mode;
   logic                            idle_has;
   cst_pkg::tok_type                idle_tok;
   logic                            has_a, has_b, rescan;
   cst_pkg::tok_type                tok_a, tok_b;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   // character classes
   assign is_digit = (req_ch >= "0") && (req_ch <= "9");
   assign is_alpha = ((req_ch >= "A") && (req_ch <= "Z")) ||
                     ((req_ch >= "a") && (req_ch <= "z"));
   assign is_space = (req_ch == " ") || ((req_ch >= 8'd9) && (req_ch <= 8'd13));

   // keyword prefix tracking
   always_comb begin
      for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
         start_flags[k] = (cst_pkg::KW_CHAR[k][0] == req_ch);
         cont_flags[k]  = flags_ff[k] && (len_ff < cst_pkg::KW_LEN[k]) &&
                          (cst_pkg::KW_CHAR[k][len_ff] == req_ch);
      end
      len_sat = (len_ff == {cst_pkg::LEN_W{1'b1}}) ? len_ff : len_ff + 1'b1;
   end

   // keyword lookup of the pending identifier, lowest keyword wins
   always_comb begin
      ident_tok = cst_pkg::TK_IDENT;
      for (int k = cst_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (flags_ff[k] && (len_ff == cst_pkg::KW_LEN[k])) begin
            ident_tok = cst_pkg::KW_TOK[k];
         end
      end
   end

   // classification of a character seen between tokens
   always_comb begin
      idle_mode = MODE_IDLE;
      idle_has  = 1'b0;
      idle_tok  = cst_pkg::TK_ERROR;
      if (is_space) begin
         idle_has = 1'b0;
      end else if (is_digit) begin
         idle_mode = MODE_INT;
      end else if (req_ch == ".") begin
         idle_mode = MODE_LEADDOT;
      end else if (is_alpha) begin
         idle_mode = MODE_IDENT;
      end else begin
         idle_has = 1'b1;
         case (req_ch)
            "<": begin
               idle_mode = MODE_LESS;
               idle_has  = 1'b0;
            end
            "+", "-": idle_tok = cst_pkg::TK_ADD;
            "*", "/": idle_tok = cst_pkg::TK_MUL;
            "(":      idle_tok = cst_pkg::TK_LPAREN;
            ")":      idle_tok = cst_pkg::TK_RPAREN;
            "=":      idle_tok = cst_pkg::TK_EQUAL;
            ";":      idle_tok = cst_pkg::TK_SEMI;
            "{":      idle_tok = cst_pkg::TK_LCURLY;
            "}":      idle_tok = cst_pkg::TK_RCURLY;
            default:  idle_tok = cst_pkg::TK_ERROR;
         endcase
      end
   end

   // scanner step: next state and up to two tokens
   always_comb begin
      mode_in  = mode_ff;
      flags_in = flags_ff;
      len_in   = len_ff;
      has_a    = 1'b0;
      has_b    = 1'b0;
      tok_a    = cst_pkg::TK_END;
      tok_b    = cst_pkg::TK_END;
      rescan   = 1'b0;
      if (req_kind == cst_pkg::KIND_EOI) begin
         // flush the pending token, then the end token
         has_a = 1'b1;
         case (mode_ff)
            MODE_INT, MODE_LEADDOT, MODE_FRAC: tok_a = cst_pkg::TK_NUM;
            MODE_IDENT:                        tok_a = ident_tok;
            MODE_LESS:                         tok_a = cst_pkg::TK_ERROR;
            default:                           has_a = 1'b0;
         endcase
         if (has_a) begin
            has_b = 1'b1;
            tok_b = cst_pkg::TK_END;
         end else begin
            has_a = 1'b1;
            tok_a = cst_pkg::TK_END;
         end
         mode_in  = MODE_IDLE;
         flags_in = '0;
         len_in   = '0;
      end else begin
         case (mode_ff)
            MODE_INT: begin
               if (req_ch == ".") begin
                  mode_in = MODE_FRAC;
               end else if (!is_digit) begin
                  has_a  = 1'b1;
                  tok_a  = cst_pkg::TK_NUM;
                  rescan = 1'b1;
               end
            end
            MODE_LEADDOT, MODE_FRAC: begin
               if (!is_digit) begin
                  has_a  = 1'b1;
                  tok_a  = cst_pkg::TK_NUM;
                  rescan = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_alpha || is_digit) begin
                  flags_in = cont_flags;
                  len_in   = len_sat;
               end else begin
                  has_a    = 1'b1;
                  tok_a    = ident_tok;
                  flags_in = '0;
                  len_in   = '0;
                  rescan   = 1'b1;
               end
            end
            MODE_LESS: begin
               has_a   = 1'b1;
               tok_a   = (req_ch == "<") ? cst_pkg::TK_LSHIFT : cst_pkg::TK_ERROR;
               mode_in = MODE_IDLE;
            end
            default: rescan = 1'b1;
         endcase
         // the terminating character starts over from idle
         if (rescan) begin
            mode_in = idle_mode;
            if (idle_mode == MODE_IDENT) begin
               flags_in = start_flags;
               len_in   = {{(cst_pkg::LEN_W-1){1'b0}}, 1'b1};
            end
            if (idle_has) begin
               if (has_a) begin
                  has_b = 1'b1;
                  tok_b = idle_tok;
               end else begin
                  has_a = 1'b1;
                  tok_a = idle_tok;
               end
            end
         end
      end
   end

   assign push             = accept && has_a;
   assign push_entry.two   = has_b;
   assign push_entry.tok_a = tok_a;
   assign push_entry.tok_b = tok_b;

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         flags_ff <= '0;
         len_ff   <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         flags_ff <= flags_in;
         len_ff   <= len_in;
      end
   end

endmodule

// ----- rtl/cst_queue.sv -----
`include "char_stream_tokenizer_assert.svh"

module cst_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cst_pkg::tok_entry_type push_entry,
   input  logic                   pop,
   output cst_pkg::tok_entry_type head_entry,
   output cst_pkg::q_status_type  q_status
);

   cst_pkg::tok_entry_type         store_ff [cst_pkg::QUEUE_DEPTH];
   logic [cst_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [cst_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [cst_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == cst_pkg::QCNT_W'(cst_pkg::QUEUE_DEPTH));
   assign head_entry     = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CST_ASSERT_NOW(a_no_overflow, push, !q_status.full)
   `CST_ASSERT_NOW(a_no_underflow, pop, !q_status.empty)

endmodule

// ----- rtl/cst_back.sv -----
`include "char_stream_tokenizer_assert.svh"

module cst_back (
   input  logic                   clock,
   input  logic                   reset,
   input  cst_pkg::tok_entry_type head_entry,
   input  cst_pkg::q_status_type  q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [4:0]             rsp_token_kind,
   output logic                   rsp_last
);

   logic             rsp_valid_ff, rsp_valid_in;
   logic [4:0]       rsp_token_kind_ff, rsp_token_kind_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             half_ff, half_in;
   logic             load, take;

   // output register frees up when empty or when its word is taken
   assign load = !rsp_valid_ff || !rsp_stall;
   assign take = load && !q_status.empty;
   assign pop  = take && (!head_entry.two || half_ff);

   // split a two-token word over two output words
   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_token_kind_in = rsp_token_kind_ff;
      rsp_last_in       = rsp_last_ff;
      half_in           = half_ff;
      if (take) begin
         rsp_valid_in      = 1'b1;
         rsp_token_kind_in = half_ff ? head_entry.tok_b : head_entry.tok_a;
         rsp_last_in       = !head_entry.two || half_ff;
         half_in           = head_entry.two && !half_ff;
      end else if (load) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff      <= half_in;
      end
      rsp_token_kind_ff <= rsp_token_kind_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_token_kind = rsp_token_kind_ff;
   assign rsp_last       = rsp_last_ff;

   `CST_ASSERT_NEXT(a_first_of_pair, take && head_entry.two && !half_ff,
                    rsp_valid_ff && !rsp_last_ff && half_ff)
   `CST_ASSERT_NEXT(a_pop_marks_last, pop, rsp_valid_ff && rsp_last_ff && !half_ff)

endmodule

// ----- rtl/char_stream_tokenizer.sv -----
// Character stream tokenizer. Each req word carries one source byte (req_kind 0)
// or an end-of-input mark (req_kind 1); each rsp word carries one token kind,
// with rsp_last set on the final token caused by a req word. Numbers, identifiers
// (int, float, cout and void are recognized as keywords), '<<' and single-character
// operators and brackets are tokenized; a byte that ends a number or identifier is
// scanned again, so one byte can give two tokens, and end of input flushes the
// pending token before the end token. The scanner takes one byte per cycle while
// req_stall is low, with a registered state update, and sends its tokens through
// a four-word queue, which raises req_stall only when full, to the output register;
// that sends one token per cycle while rsp_stall is low, one rsp word per token.
module char_stream_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_ch,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_token_kind,
   output logic       rsp_last
);

   cst_pkg::q_status_type  q_status;
   cst_pkg::tok_entry_type push_entry;
   cst_pkg::tok_entry_type head_entry;
   logic                   push;
   logic                   pop;

   // scanner
   cst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_kind   (req_kind),
      .req_ch     (req_ch),
      .req_stall  (req_stall),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // token queue
   cst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   // output side
   cst_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_kind (rsp_token_kind),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- test/char_stream_tokenizer_tb.sv -----
module char_stream_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_WORDS   = 1250;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int TAIL_CYCLES = 20;
   localparam int MAX_SHOWN   = 10;

   // scanner modes of the predictor
   typedef enum logic [2:0] {
      SM_IDLE    = 3'd0,
      SM_INT     = 3'd1,
      SM_LEADDOT = 3'd2,
      SM_FRAC    = 3'd3,
      SM_IDENT   = 3'd4,
      SM_LESS    = 3'd5
   } scan_mode_type;

   // one token expected on the rsp channel
   typedef struct packed {
      cst_pkg::tok_type tok;
      logic             last;
   } tok_word_type;

   // one directed word; typed rows carry their tokens, the rest use the predictor
   typedef struct packed {
      logic             kind;
      logic [7:0]       ch;
      logic             typed;
      logic [1:0]       n;
      cst_pkg::tok_type t0;
      cst_pkg::tok_type t1;
   } dir_row_type;

   localparam dir_row_type DIRECTED [26] = '{
      '{cst_pkg::KIND_CHAR, "+",   1'b1, 2'd1, cst_pkg::TK_ADD,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "-",   1'b1, 2'd1, cst_pkg::TK_ADD,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "*",   1'b1, 2'd1, cst_pkg::TK_MUL,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "/",   1'b1, 2'd1, cst_pkg::TK_MUL,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "(",   1'b1, 2'd1, cst_pkg::TK_LPAREN, cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, ")",   1'b1, 2'd1, cst_pkg::TK_RPAREN, cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, 8'h00, 1'b1, 2'd1, cst_pkg::TK_ERROR,  cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, 8'hFF, 1'b1, 2'd1, cst_pkg::TK_ERROR,  cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, " ",   1'b1, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "<",   1'b1, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "<",   1'b1, 2'd1, cst_pkg::TK_LSHIFT, cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "<",   1'b1, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "a",   1'b1, 2'd1, cst_pkg::TK_ERROR,  cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "i",   1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "n",   1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "t",   1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, ";",   1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "7",   1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, ".",   1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "}",   1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, ".",   1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "v",   1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_EOI,  8'h00, 1'b0, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_CHAR, "<",   1'b1, 2'd0, cst_pkg::TK_END,    cst_pkg::TK_END},
      '{cst_pkg::KIND_EOI,  8'hA5, 1'b1, 2'd2, cst_pkg::TK_ERROR,  cst_pkg::TK_END},
      '{cst_pkg::KIND_EOI,  8'h5A, 1'b1, 2'd1, cst_pkg::TK_END,    cst_pkg::TK_END}
   };

   // keywords and near misses for the random part
   string near_words [10] = '{"int", "float", "cout", "void", "in",
                              "flo", "integer", "voids", "co", "Int"};
   string op_chars = "+-*/()=;{}";

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_kind = cst_pkg::KIND_CHAR;
   logic [7:0] req_ch = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [4:0] rsp_token_kind;
   logic       rsp_last;

   // predictor state
   scan_mode_type scan_mode;
   logic [3:0]    kw_flags;
   logic [2:0]    id_len;

   tok_word_type  expected_tokens [$];
   tok_word_type  want;
   int            n_fail = 0;
   int            words_sent = 0;
   int            eoi_sent = 0;
   int            tokens_checked = 0;
   int            cycle_cnt = 0;
   int            stall_left = 0;

   char_stream_tokenizer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_kind (rsp_token_kind),
      .rsp_last       (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // character classes
   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic void clear_scan();
      scan_mode = SM_IDLE;
      kw_flags  = 4'b0000;
      id_len    = 3'd0;
   endfunction

   // keyword whose prefix flag survived and whose length matches, else identifier
   function automatic cst_pkg::tok_type word_token();
      for (int k = 0; k < cst_pkg::NUM_KW; k++)
         if (kw_flags[k] && id_len == cst_pkg::KW_LEN[k]) return cst_pkg::KW_TOK[k];
      return cst_pkg::TK_IDENT;
   endfunction

   // extend the identifier, dropping keywords it no longer matches
   function automatic void grow_word(input logic [7:0] c);
      for (int k = 0; k < cst_pkg::NUM_KW; k++)
         if (!(kw_flags[k] && id_len < cst_pkg::KW_LEN[k] &&
               cst_pkg::KW_CHAR[k][id_len] == c))
            kw_flags[k] = 1'b0;
      if (id_len != 3'd7) id_len = id_len + 3'd1;
   endfunction

   // scan one byte starting between tokens
   function automatic void from_idle(input logic [7:0] c, output bit has,
                                     output cst_pkg::tok_type t);
      has = 1'b1;
      t = cst_pkg::TK_ERROR;
      scan_mode = SM_IDLE;
      if (is_space(c)) begin
         has = 1'b0;
      end else if (is_digit(c)) begin
         scan_mode = SM_INT;
         has = 1'b0;
      end else if (c == ".") begin
         scan_mode = SM_LEADDOT;
         has = 1'b0;
      end else if (is_alpha(c)) begin
         scan_mode = SM_IDENT;
         kw_flags = 4'b1111;
         id_len = 3'd0;
         grow_word(c);
         has = 1'b0;
      end else begin
         case (c)
            "<": begin
               scan_mode = SM_LESS;
               has = 1'b0;
            end
            "+", "-": t = cst_pkg::TK_ADD;
            "*", "/": t = cst_pkg::TK_MUL;
            "(": t = cst_pkg::TK_LPAREN;
            ")": t = cst_pkg::TK_RPAREN;
            "=": t = cst_pkg::TK_EQUAL;
            ";": t = cst_pkg::TK_SEMI;
            "{": t = cst_pkg::TK_LCURLY;
            "}": t = cst_pkg::TK_RCURLY;
            default: t = cst_pkg::TK_ERROR;
         endcase
      end
   endfunction

   // tokens caused by one accepted word, state advanced
   function automatic void scan_word(input logic kind, input logic [7:0] c,
                                     output int n, output cst_pkg::tok_type t0,
                                     output cst_pkg::tok_type t1);
      cst_pkg::tok_type got [2];
      bit               again;
      bit               has;
      cst_pkg::tok_type t;
      n = 0;
      again = 1'b0;
      got[0] = cst_pkg::TK_END;
      got[1] = cst_pkg::TK_END;
      if (kind == cst_pkg::KIND_EOI) begin
         // flush the pending token, then the end token
         case (scan_mode)
            SM_INT, SM_LEADDOT, SM_FRAC: begin
               got[n] = cst_pkg::TK_NUM;
               n++;
            end
            SM_IDENT: begin
               got[n] = word_token();
               n++;
            end
            SM_LESS: begin
               got[n] = cst_pkg::TK_ERROR;
               n++;
            end
            default: ;
         endcase
         got[n] = cst_pkg::TK_END;
         n++;
         clear_scan();
      end else begin
         case (scan_mode)
            SM_INT: begin
               if (!is_digit(c)) begin
                  if (c == ".") begin
                     scan_mode = SM_FRAC;
                  end else begin
                     got[n] = cst_pkg::TK_NUM;
                     n++;
                     again = 1'b1;
                  end
               end
            end
            SM_LEADDOT, SM_FRAC: begin
               if (!is_digit(c)) begin
                  got[n] = cst_pkg::TK_NUM;
                  n++;
                  again = 1'b1;
               end
            end
            SM_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  grow_word(c);
               end else begin
                  got[n] = word_token();
                  n++;
                  kw_flags = 4'b0000;
                  id_len = 3'd0;
                  again = 1'b1;
               end
            end
            // second byte after '<' is consumed either way
            SM_LESS: begin
               got[n] = (c == "<") ? cst_pkg::TK_LSHIFT : cst_pkg::TK_ERROR;
               n++;
               scan_mode = SM_IDLE;
            end
            default: again = 1'b1;
         endcase
         if (again) begin
            from_idle(c, has, t);
            if (has) begin
               got[n] = t;
               n++;
            end
         end
      end
      t0 = got[0];
      t1 = got[1];
   endfunction

   function automatic void queue_tokens(input int n, input cst_pkg::tok_type t0,
                                        input cst_pkg::tok_type t1);
      if (n > 0) expected_tokens.push_back(tok_word_type'{t0, n == 1});
      if (n > 1) expected_tokens.push_back(tok_word_type'{t1, 1'b1});
   endfunction

   function automatic void note_failure(input string msg);
      n_fail++;
      if (n_fail <= MAX_SHOWN) $display("mismatch: %s", msg);
   endfunction

   // mostly short idle runs, now and then a long one
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 93) return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] rand_alpha();
      logic [7:0] base;
      base = $urandom_range(0, 1) ? "A" : "a";
      return base + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] rand_digit();
      return "0" + 8'($urandom_range(0, 9));
   endfunction

   // present one word and hold it until accepted
   task automatic send_word(input logic kind, input logic [7:0] c);
      int gap;
      gap = 0;
      if (((words_sent / 50) % 6) != 0 && $urandom_range(0, 99) >= 55) gap = pick_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_ch    <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (kind == cst_pkg::KIND_EOI) eoi_sent++;
   endtask

   task automatic feed(input logic kind, input logic [7:0] c);
      int               n;
      cst_pkg::tok_type t0;
      cst_pkg::tok_type t1;
      send_word(kind, c);
      scan_word(kind, c, n, t0, t1);
      queue_tokens(n, t0, t1);
   endtask

   task automatic feed_text(input string s);
      for (int i = 0; i < s.len(); i++) feed(cst_pkg::KIND_CHAR, s[i]);
   endtask

   // one random fragment: mostly well-formed tokens, some noise
   task automatic random_fragment();
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 18) begin
         feed_text(near_words[$urandom_range(0, 9)]);
      end else if (r < 35) begin
         len = $urandom_range(1, 10);
         feed(cst_pkg::KIND_CHAR, rand_alpha());
         for (int i = 1; i < len; i++)
            feed(cst_pkg::KIND_CHAR,
                 ($urandom_range(0, 99) < 70) ? rand_alpha() : rand_digit());
      end else if (r < 52) begin
         case ($urandom_range(0, 2))
            0: repeat ($urandom_range(1, 5)) feed(cst_pkg::KIND_CHAR, rand_digit());
            1: begin
               repeat ($urandom_range(1, 4)) feed(cst_pkg::KIND_CHAR, rand_digit());
               feed(cst_pkg::KIND_CHAR, ".");
               repeat ($urandom_range(0, 3)) feed(cst_pkg::KIND_CHAR, rand_digit());
            end
            default: begin
               feed(cst_pkg::KIND_CHAR, ".");
               repeat ($urandom_range(1, 3)) feed(cst_pkg::KIND_CHAR, rand_digit());
            end
         endcase
      end else if (r < 67) begin
         feed(cst_pkg::KIND_CHAR, op_chars[$urandom_range(0, 9)]);
      end else if (r < 72) begin
         feed_text("<<");
      end else if (r < 82) begin
         len = $urandom_range(8, 13);
         feed(cst_pkg::KIND_CHAR, (len == 8) ? " " : 8'(len));
      end else if (r < 88) begin
         // broken shift: '<' then any byte
         feed(cst_pkg::KIND_CHAR, "<");
         feed(cst_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
      end else if (r < 97) begin
         feed(cst_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
      end else begin
         feed(cst_pkg::KIND_EOI, 8'($urandom_range(0, 255)));
      end
      // separate words with a blank now and then
      if (r < 52 && $urandom_range(0, 99) < 40) feed(cst_pkg::KIND_CHAR, " ");
   endtask

   // stimulus: directed table, random fragments, drain, verdict
   initial begin : stimulus
      int               n;
      cst_pkg::tok_type t0;
      cst_pkg::tok_type t1;
      clear_scan();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (DIRECTED[i]) begin
         send_word(DIRECTED[i].kind, DIRECTED[i].ch);
         scan_word(DIRECTED[i].kind, DIRECTED[i].ch, n, t0, t1);
         if (DIRECTED[i].typed) begin
            n  = int'(DIRECTED[i].n);
            t0 = DIRECTED[i].t0;
            t1 = DIRECTED[i].t1;
         end
         queue_tokens(n, t0, t1);
      end

      // random part
      while (words_sent < NUM_WORDS) random_fragment();
      req_valid <= 1'b0;

      // drain
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d words (%0d end-of-input marks), checked %0d tokens, %0d mismatches",
               words_sent, eoi_sent, tokens_checked, n_fail);
      if (n_fail == 0) begin
         $display("char_stream_tokenizer_tb: PASS");
      end else begin
         $display("char_stream_tokenizer_tb: FAIL");
      end
      $finish;
   end

   // rsp side: check each accepted token, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            note_failure($sformatf("token %0d last %0b with nothing expected",
                                   rsp_token_kind, rsp_last));
         end else begin
            want = expected_tokens.pop_front();
            tokens_checked++;
            if (rsp_token_kind !== want.tok)
               note_failure($sformatf("token kind expected %0d got %0d",
                                      want.tok, rsp_token_kind));
            if (rsp_last !== want.last)
               note_failure($sformatf("last expected %0b got %0b (token %0d)",
                                      want.last, rsp_last, want.tok));
         end
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ((cycle_cnt % 1200) < 150 || $urandom_range(0, 99) < 75) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_left = pick_len() - 1;
         rsp_stall <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("char_stream_tokenizer_tb: FAIL");
         $finish;
      end
   end

endmodule
